// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, sampled on clk, off while reset is held.
`define BDA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("bda assertion failed");

// Same check, but also active during reset.
`define BDA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("bda assertion failed");

`endif

// ===== rtl/bda_pkg.sv =====
// Shared types and constants of the binary to decimal ASCII converter.
package bda_pkg;

  localparam int unsigned ValueW    = 64;
  localparam int unsigned SizeW     = 8;
  localparam int unsigned CharW     = 8;
  localparam int unsigned PosW      = 5;
  localparam int unsigned NumDigits = 20;
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned BitCntW   = $clog2(ValueW);

  localparam logic [CharW-1:0] AsciiZero = 8'd48;
  localparam logic [CharW-1:0] CharNul   = 8'd0;

  // Per-word job info handed from the top level to the emitter
  typedef struct packed {
    logic [SizeW-1:0] capacity;
    logic             zero;
  } bda_job_t;

endpackage

// ===== rtl/bda_if.sv =====
// Valid/ready channel interfaces of the converter.
interface bda_in_if;
  import bda_pkg::*;
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;
  logic [SizeW-1:0]  capacity;

  modport source (output valid, output value, output capacity, input ready);
  modport sink   (input valid, input value, input capacity, output ready);
endinterface

interface bda_out_if;
  import bda_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic [PosW-1:0]  position;
  logic             last;

  modport source (output valid, output char_code, output position, output last,
                  input ready);
  modport sink   (input valid, input char_code, input position, input last,
                  output ready);
endinterface

// ===== rtl/binary_to_decimal_ascii.sv =====
// Top level of the 64-bit binary to decimal ASCII converter.
//
//   channel | dir | payload                             | handshake
//   in_i    | in  | value[63:0], capacity[7:0]          | valid/ready
//   out_o   | out | char_code[7:0], position[4:0], last | valid/ready
//
// One input word goes through bit-serial double-dabble, a handoff to the emitter,
// a skip of up to 19 leading zeros, then one character per cycle while out_o is
// ready (up to 21 characters).
// in_i.ready is high only while no word is in flight.
// A stall on out_o holds the current character.
// Reset is async, active low.
`include "assert_macros.svh"

module binary_to_decimal_ascii import bda_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  bda_in_if.sink    in_i,
  bda_out_if.source out_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]      state_q, state_d;
  bda_job_t        job_q, job_d;
  logic            accept;
  logic            conv_done;
  logic            emit_done;
  logic [BcdW-1:0] bcd;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          job_d.capacity = in_i.capacity;
          job_d.zero     = (in_i.value == '0);
          state_d        = S_CONV;
        end
      end
      S_CONV: begin
        // a word with nothing to print finishes at the load itself
        if (conv_done) begin
          state_d = emit_done ? S_IDLE : S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  bda_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .value_i (in_i.value),
    .bcd_o   (bcd),
    .done_o  (conv_done)
  );

  // conv_done is a one-cycle pulse with the final digits already in bcd
  bda_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (state_q == S_CONV && conv_done),
    .job_i  (job_q),
    .bcd_i  (bcd),
    .done_o (emit_done),
    .out_o  (out_o)
  );

  `BDA_ASSERT(a_emit_done_only_emit, clk_i, rst_ni,
    emit_done |-> ((state_q == S_EMIT) || (state_q == S_CONV && conv_done)))
  `BDA_ASSERT(a_no_output_while_conv, clk_i, rst_ni,
    (state_q == S_CONV) |-> !out_o.valid)

endmodule

// ===== rtl/bda_dabble.sv =====
// Bit-serial double-dabble: binary value to 20 BCD digits, one bit per cycle.
`include "assert_macros.svh"

module bda_dabble import bda_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ValueW-1:0] value_i,
  output logic [BcdW-1:0]   bcd_o,
  output logic              done_o
);

  logic [ValueW-1:0]  bin_q, bin_d;
  logic [BcdW-1:0]    bcd_q, bcd_d, bcd_adj;
  logic [BitCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      bin_d  = value_i;
      bcd_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = {bcd_adj[BcdW-2:0], bin_q[ValueW-1]};
      bin_d = {bin_q[ValueW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == BitCntW'(ValueW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  // done pulses once the last shift has landed in bcd_q
  assign done_o = done_q;
  assign bcd_o  = bcd_q;

  `BDA_ASSERT(a_done_ends_run, clk_i, rst_ni, done_o |-> !busy_q)
  `BDA_ASSERT(a_no_restart, clk_i, rst_ni, (busy_q && !done_d) |=> busy_q)

endmodule

// ===== rtl/bda_emit.sv =====
// Digit emitter: skips leading zeros, then sends one character per cycle while out_o is ready.
`include "assert_macros.svh"

module bda_emit import bda_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  bda_job_t        job_i,
  input  logic [BcdW-1:0] bcd_i,
  output logic            done_o,
  bda_out_if.source       out_o
);

  localparam logic [1:0] E_IDLE  = 2'd0;
  localparam logic [1:0] E_SKIP  = 2'd1;
  localparam logic [1:0] E_EMIT  = 2'd2;
  localparam logic [1:0] E_DRAIN = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [BcdW-1:0]  bcd_q, bcd_d;
  logic [SizeW-1:0] room_q, room_d;
  logic [PosW-1:0]  dleft_q, dleft_d;
  logic [PosW-1:0]  posn_q, posn_d;
  logic             ovalid_q, ovalid_d;
  logic [CharW-1:0] char_q, char_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             last_q, last_d;
  logic             drop;
  logic [3:0]       top_digit;

  // Nothing at all for zero capacity, or for a zero value with room for one byte
  assign drop = (job_i.capacity == '0) ||
                (job_i.zero && (job_i.capacity == SizeW'(1)));
  assign top_digit = bcd_q[BcdW-1 -: 4];

  always_comb begin
    state_d  = state_q;
    bcd_d    = bcd_q;
    room_d   = room_q;
    dleft_d  = dleft_q;
    posn_d   = posn_q;
    ovalid_d = ovalid_q;
    char_d   = char_q;
    pos_d    = pos_q;
    last_d   = last_q;
    done_o   = 1'b0;
    case (state_q)
      E_IDLE: begin
        ovalid_d = 1'b0;
        if (load_i) begin
          bcd_d   = bcd_i;
          room_d  = job_i.capacity - 1'b1;
          dleft_d = PosW'(NumDigits);
          posn_d  = '0;
          if (drop) begin
            done_o = 1'b1;
          end else begin
            state_d = E_SKIP;
          end
        end
      end
      E_SKIP: begin
        // keep at least one digit so a zero value still prints '0'
        if (top_digit == 4'd0 && dleft_q > PosW'(1)) begin
          bcd_d   = {bcd_q[BcdW-5:0], 4'd0};
          dleft_d = dleft_q - 1'b1;
        end else begin
          state_d = E_EMIT;
        end
      end
      E_EMIT: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d = 1'b1;
          pos_d    = posn_q;
          if ((SizeW'(posn_q) < room_q) && (dleft_q != '0)) begin
            char_d  = AsciiZero | CharW'(top_digit);
            last_d  = 1'b0;
            bcd_d   = {bcd_q[BcdW-5:0], 4'd0};
            dleft_d = dleft_q - 1'b1;
            posn_d  = posn_q + 1'b1;
          end else begin
            char_d  = CharNul;
            last_d  = 1'b1;
            state_d = E_DRAIN;
          end
        end
      end
      E_DRAIN: begin
        if (out_o.ready) begin
          ovalid_d = 1'b0;
          state_d  = E_IDLE;
          done_o   = 1'b1;
        end
      end
      default: begin
        state_d  = E_IDLE;
        ovalid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= E_IDLE;
      ovalid_q <= 1'b0;
      dleft_q  <= '0;
      posn_q   <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      dleft_q  <= dleft_d;
      posn_q   <= posn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q  <= bcd_d;
    room_q <= room_d;
    char_q <= char_d;
    pos_q  <= pos_d;
    last_q <= last_d;
  end

  assign out_o.valid     = ovalid_q;
  assign out_o.char_code = char_q;
  assign out_o.position  = pos_q;
  assign out_o.last      = last_q;

  `BDA_ASSERT(a_last_only_in_drain, clk_i, rst_ni,
    (ovalid_q && last_q) |-> (state_q == E_DRAIN))
  `BDA_ASSERT(a_digit_fits_room, clk_i, rst_ni,
    (ovalid_q && !last_q) |-> (SizeW'(pos_q) < room_q))
  `BDA_ASSERT_ALWAYS(a_idle_no_word, clk_i,
    (state_q == E_IDLE) |-> !ovalid_q)

endmodule
